// ===== src/lfac_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the line follow / align controller.
// No dependencies; imported by the top level and its checker.
package lfac_pkg;

    // Default build values
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int SMOOTH_COUNT_DEF = 10;
    localparam int MS_BITS_DEF      = 16;

    // Fixed field widths
    localparam int REQ_W     = 2;
    localparam int FIELD_S_W = 12;   // sample field on the bus
    localparam int FIELD_MS_W = 16;  // align_ms field on the bus
    localparam int THR_W     = 12;
    localparam int DUTY_W    = 10;
    localparam int PHASE_W   = 2;
    localparam int CNT_W     = 4;    // priming counter, holds up to 15

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // Output beat bit positions
    localparam int OB_LFWD  = 0;
    localparam int OB_RFWD  = 1;
    localparam int OB_LCMP  = 2;
    localparam int OB_RCMP  = 12;
    localparam int OB_LSEEN = 22;
    localparam int OB_RSEEN = 23;
    localparam int OB_BUSY  = 24;
    localparam int OB_USED  = 25;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY      = 2'd2;

    localparam logic [THR_W-1:0]  LEFT_THR_RST  = 12'd900;
    localparam logic [THR_W-1:0]  RIGHT_THR_RST = 12'd600;
    localparam logic [DUTY_W-1:0] DUTY_RST      = 10'd800;
    localparam logic [DUTY_W-1:0] STOP_COMPARE  = 10'd1000;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 2'd0,
        PH_PRIME  = 2'd1,
        PH_FOLLOW = 2'd2,
        PH_ALIGN  = 2'd3
    } t_phase;

    typedef enum logic [REQ_W-1:0] {
        REQ_START  = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_TICK   = 2'd2
    } t_req;

endpackage

// ===== src/line_follow_align_controller_unit.sv =====
`timescale 1ns / 1ps
// Line follow / align controller: filters two IR samples, steers two wheels.
// Latency: the result beat is valid on the cycle after its input beat is taken.
// Throughput: one beat per cycle unless stalled; the filter update, threshold compare
// and phase step are one pass of logic from the state registers to the result register.
// Reset (synchronous, active low): idle, filters and counters zero, wheels stopped,
// thresholds 900/600, drive duty 800, no result pending.
// Depends on lfac_pkg.
module line_follow_align_controller_unit #(
    parameter int SAMPLE_BITS  = lfac_pkg::SAMPLE_BITS_DEF,
    parameter int SMOOTH_COUNT = lfac_pkg::SMOOTH_COUNT_DEF,
    parameter int MS_BITS      = lfac_pkg::MS_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // cfg write port
    input  logic                               i_cfg_wr_en,
    input  logic [lfac_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [lfac_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [11:0] left_sample, [23:12] right_sample, [39:24] align_ms
    input  logic [lfac_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [1:0] req_type
    input  logic [lfac_pkg::S_TUSER_W-1:0]     i_s_tuser,
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] left_forward, [1] right_forward, [11:2] left_compare,
    // [21:12] right_compare, [22] left_line_seen, [23] right_line_seen,
    // [24] busy_res, [31:25] zero
    output logic [lfac_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // done_res
    output logic                               o_m_tlast,
    // [1:0] phase
    output logic [lfac_pkg::M_TUSER_W-1:0]     o_m_tuser
);
    import lfac_pkg::*;

    // filter arithmetic: t = (C-1)*acc + s < 2^SUM_W, q = t*RECIP >> SHIFT is exact
    localparam int SUM_W       = SAMPLE_BITS + CNT_W;
    localparam int RECIP_SHIFT = SUM_W + CNT_W;
    localparam int RECIP_W     = RECIP_SHIFT;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + SMOOTH_COUNT - 1) / SMOOTH_COUNT;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    function automatic logic [SAMPLE_BITS-1:0] f_smooth(
        input logic [SAMPLE_BITS-1:0] acc,
        input logic [SAMPLE_BITS-1:0] smp
    );
        logic [SUM_W-1:0]  t;
        logic [PROD_W-1:0] p;
        t = SUM_W'(acc) * SUM_W'(SMOOTH_COUNT - 1) + SUM_W'(smp);
        p = PROD_W'(t) * PROD_W'(RECIP);
        return p[RECIP_SHIFT +: SAMPLE_BITS];
    endfunction

    // config
    logic [THR_W-1:0]  r_left_thr;
    logic [THR_W-1:0]  r_right_thr;
    logic [DUTY_W-1:0] r_duty;

    // state
    t_phase                 r_phase,  n_phase;
    logic [SAMPLE_BITS-1:0] r_lfilt,  n_lfilt;
    logic [SAMPLE_BITS-1:0] r_rfilt,  n_rfilt;
    logic [CNT_W-1:0]       r_cnt,    n_cnt;
    logic [MS_BITS-1:0]     r_rem,    n_rem;
    logic [1:0]             r_drive,  n_drive;
    logic [1:0]             r_flags,  n_flags;
    logic                   n_done;

    // result register
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_tdata,  n_tdata;
    logic                   r_tlast;
    logic [M_TUSER_W-1:0]   r_tuser,  n_tuser;

    logic                   in_beat;
    t_req                   req;
    logic [SAMPLE_BITS-1:0] lsmp, rsmp;
    logic [SAMPLE_BITS-1:0] lsm, rsm;
    logic [MS_BITS-1:0]     ms_in;
    logic [MS_BITS-1:0]     rem_dec;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   lseen, rseen;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_beat    = i_s_tvalid && o_s_tready;

    assign req   = t_req'(i_s_tuser[REQ_W-1:0]);
    assign lsmp  = SAMPLE_BITS'(i_s_tdata[FIELD_S_W-1:0]);
    assign rsmp  = SAMPLE_BITS'(i_s_tdata[2*FIELD_S_W-1:FIELD_S_W]);
    assign ms_in = MS_BITS'(i_s_tdata[2*FIELD_S_W +: FIELD_MS_W]);

    assign lsm     = f_smooth(r_lfilt, lsmp);
    assign rsm     = f_smooth(r_rfilt, rsmp);
    assign lseen   = CMP_W'(lsm) >= CMP_W'(r_left_thr);
    assign rseen   = CMP_W'(rsm) >= CMP_W'(r_right_thr);
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign rem_dec = (r_rem == '0) ? '0 : r_rem - MS_BITS'(1);

    // next state
    always_comb begin
        logic eval_en;
        eval_en  = 1'b0;
        n_phase  = r_phase;
        n_lfilt  = r_lfilt;
        n_rfilt  = r_rfilt;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_drive  = r_drive;
        n_flags  = r_flags;
        n_done   = 1'b0;
        case (req)
            REQ_START: begin
                n_lfilt = lsmp;
                n_rfilt = rsmp;
                n_cnt   = '0;
                n_rem   = ms_in;
                n_drive = 2'b00;
                n_flags = 2'b00;
                n_phase = PH_PRIME;
            end
            REQ_SAMPLE: begin
                if (r_phase == PH_PRIME) begin
                    n_lfilt = lsm;
                    n_rfilt = rsm;
                    n_cnt   = cnt_inc;
                    eval_en = cnt_inc >= CNT_W'(SMOOTH_COUNT);
                end else if (r_phase == PH_FOLLOW) begin
                    n_lfilt = lsm;
                    n_rfilt = rsm;
                    eval_en = 1'b1;
                end
            end
            REQ_TICK: begin
                if (r_phase == PH_ALIGN) begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_drive = 2'b00;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (eval_en) begin
            if (lseen && rseen) begin
                n_flags = 2'b00;
                if (r_rem == '0) begin
                    // zero align time: stop on this same beat
                    n_drive = 2'b00;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_drive = 2'b11;
                    n_phase = PH_ALIGN;
                end
            end else begin
                n_flags = {rseen, lseen};
                n_drive = {!rseen, !lseen};
                n_phase = PH_FOLLOW;
            end
        end
    end

    // result beat from the post-update state
    always_comb begin
        n_tdata                              = '0;
        n_tdata[OB_LFWD]                     = n_drive[0];
        n_tdata[OB_RFWD]                     = n_drive[1];
        n_tdata[OB_LCMP +: DUTY_W]           = n_drive[0] ? r_duty : STOP_COMPARE;
        n_tdata[OB_RCMP +: DUTY_W]           = n_drive[1] ? r_duty : STOP_COMPARE;
        n_tdata[OB_LSEEN]                    = n_flags[0];
        n_tdata[OB_RSEEN]                    = n_flags[1];
        n_tdata[OB_BUSY]                     = n_phase != PH_IDLE;
        n_tuser                              = M_TUSER_W'(n_phase);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_thr  <= LEFT_THR_RST;
            r_right_thr <= RIGHT_THR_RST;
            r_duty      <= DUTY_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_LEFT_THR:  r_left_thr  <= i_cfg_data[THR_W-1:0];
                CFG_RIGHT_THR: r_right_thr <= i_cfg_data[THR_W-1:0];
                CFG_DUTY:      r_duty      <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_lfilt     <= '0;
            r_rfilt     <= '0;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_drive     <= 2'b00;
            r_flags     <= 2'b00;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_phase     <= n_phase;
                r_lfilt     <= n_lfilt;
                r_rfilt     <= n_rfilt;
                r_cnt       <= n_cnt;
                r_rem       <= n_rem;
                r_drive     <= n_drive;
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_tdata <= n_tdata;
            r_tlast <= n_done;
            r_tuser <= n_tuser;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tlast  = r_tlast;
    assign o_m_tuser  = r_tuser;

endmodule

// ===== src/lfac_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the line follow / align controller, bound to the top.
// Depends on lfac_pkg.
module lfac_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [lfac_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic                            o_m_tlast,
    input logic [lfac_pkg::M_TUSER_W-1:0]  o_m_tuser
);
    import lfac_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    // every accepted request yields a result on the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted request produced no result");

    // done ends the sequence: idle, not busy, wheels stopped
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser == PH_IDLE && !o_m_tdata[OB_BUSY]
            && !o_m_tdata[OB_LFWD] && !o_m_tdata[OB_RFWD])
        else $error("done beat not idle with wheels stopped");

    // busy mirrors phase
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OB_BUSY] == (o_m_tuser != PH_IDLE))
        else $error("busy does not match phase");

    // line flags only while following, and a wheel on a seen line is stopped
    a_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[OB_LSEEN] || o_m_tdata[OB_RSEEN]) |->
            o_m_tuser == PH_FOLLOW
            && !(o_m_tdata[OB_LSEEN] && o_m_tdata[OB_LFWD])
            && !(o_m_tdata[OB_RSEEN] && o_m_tdata[OB_RFWD]))
        else $error("line flag outside following or wheel driving on line");

endmodule

bind line_follow_align_controller_unit lfac_checker u_lfac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
